/* hdl/assert_macros.svh */
//------------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms used by the supervisor rtl
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/cmsup_pkg.sv */
//------------------------------------------------------------------------------
// cmsup_pkg
// types and constants of the converter mode supervisor
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmsup_pkg;

   localparam int STATUS_W   = 3;
   localparam int THR_W      = 12;
   localparam int DELAY_W    = 16;
   localparam int MEAS_W     = 60;
   localparam int LANES      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MODE_W     = 3;

   localparam int SAMPLE_WIDTH_DEF = 12;
   localparam int COUNT_WIDTH_DEF  = 16;

   localparam logic [THR_W-1:0]   FAIL_THRESHOLD_RST = '0;
   localparam logic [DELAY_W-1:0] READY_DELAY_RST    = DELAY_W'(100);

   typedef enum logic [STATUS_W-1:0] {
      ST_NORMAL   = 3'd0,
      ST_OVER     = 3'd1,
      ST_UNDER    = 3'd2,
      ST_DERATING = 3'd3,
      ST_FAULT    = 3'd4
   } status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_READY    = 3'd0,
      MODE_NORMAL   = 3'd1,
      MODE_DERATING = 3'd2,
      MODE_FAULT    = 3'd3,
      MODE_FAILURE  = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAIL_THRESHOLD = 2'd0,
      CSR_READY_DELAY    = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [STATUS_W-1:0] hv_voltage;
      logic [STATUS_W-1:0] hv_current;
      logic [STATUS_W-1:0] lv_voltage;
      logic [STATUS_W-1:0] lv_current;
      logic [STATUS_W-1:0] temperature;
      logic [STATUS_W-1:0] battery;
      logic [STATUS_W-1:0] lv_overcurrent;
      logic [STATUS_W-1:0] bus_off;
      logic [STATUS_W-1:0] bus_timeout;
      logic                enable;
   } status_bus_type;

endpackage

/* hdl/cmsup_lane.sv */
//------------------------------------------------------------------------------
// cmsup_lane
// one measurement lane: signed compare against the failure threshold
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmsup_lane #(
   parameter int SAMPLE_WIDTH = cmsup_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic signed [SAMPLE_WIDTH-1:0]     sample,
   input  logic signed [cmsup_pkg::THR_W-1:0] threshold,
   output logic                               hit
);

   logic signed [cmsup_pkg::THR_W-1:0] sample_ext;

   assign sample_ext = cmsup_pkg::THR_W'(sample);
   assign hit        = (sample_ext <= threshold);

endmodule

/* hdl/cmsup_mode.sv */
//------------------------------------------------------------------------------
// cmsup_mode
// merges lane results with status decode; mode state machine and ready counter
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmsup_mode #(
   parameter int COUNT_WIDTH = cmsup_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  cmsup_pkg::status_bus_type           status,
   input  logic [cmsup_pkg::LANES-1:0]         lane_hit,
   input  logic [cmsup_pkg::DELAY_W-1:0]       ready_delay,
   output cmsup_pkg::mode_type                 mode_next
);

   cmsup_pkg::mode_type    mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   fail_hit;
   logic                   fault_hit;
   logic                   all_normal;
   logic                   ready_flags;
   logic                   delay_met;
   logic                   hv_return;

   assign fail_hit = |lane_hit;

   always_comb begin
      fault_hit = (status.hv_voltage inside {cmsup_pkg::ST_OVER, cmsup_pkg::ST_UNDER})
               || (status.hv_current == cmsup_pkg::ST_OVER)
               || (status.lv_voltage inside {cmsup_pkg::ST_OVER, cmsup_pkg::ST_UNDER})
               || (status.lv_current == cmsup_pkg::ST_OVER)
               || (status.temperature inside {cmsup_pkg::ST_OVER, cmsup_pkg::ST_UNDER})
               || (status.battery == cmsup_pkg::ST_OVER)
               || (status.lv_overcurrent == cmsup_pkg::ST_FAULT);
      all_normal = (status.hv_current == cmsup_pkg::ST_NORMAL)
                && (status.hv_voltage == cmsup_pkg::ST_NORMAL)
                && (status.lv_current == cmsup_pkg::ST_NORMAL)
                && (status.lv_voltage == cmsup_pkg::ST_NORMAL)
                && (status.temperature == cmsup_pkg::ST_NORMAL)
                && (status.battery == cmsup_pkg::ST_NORMAL)
                && (status.lv_overcurrent == cmsup_pkg::ST_NORMAL)
                && (status.bus_off == cmsup_pkg::ST_NORMAL);
      ready_flags = (status.lv_voltage == cmsup_pkg::ST_NORMAL)
                 && (status.temperature == cmsup_pkg::ST_NORMAL)
                 && (status.bus_off == cmsup_pkg::ST_NORMAL)
                 && (status.bus_timeout == cmsup_pkg::ST_NORMAL);
      hv_return = (status.hv_voltage inside {cmsup_pkg::ST_OVER, cmsup_pkg::ST_UNDER})
               && !status.enable;
      delay_met = (cmsup_pkg::DELAY_W'(count_ff) >= ready_delay);
   end

   always_comb begin
      mode_in  = cmsup_pkg::MODE_READY;
      count_in = count_ff;
      case (mode_ff)
         cmsup_pkg::MODE_READY: begin
            if (fail_hit) begin
               mode_in  = cmsup_pkg::MODE_FAILURE;
               count_in = '0;
            end else if (!ready_flags) begin
               mode_in  = cmsup_pkg::MODE_READY;
               count_in = '0;
            end else if (delay_met) begin
               mode_in  = cmsup_pkg::MODE_NORMAL;
            end else begin
               mode_in  = cmsup_pkg::MODE_READY;
               if (!(&count_ff)) begin
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
         end
         cmsup_pkg::MODE_NORMAL: begin
            if (fail_hit) begin
               mode_in  = cmsup_pkg::MODE_FAILURE;
               count_in = '0;
            end else if (fault_hit) begin
               mode_in  = cmsup_pkg::MODE_FAULT;
               count_in = '0;
            end else if (hv_return) begin
               mode_in  = cmsup_pkg::MODE_READY;
            end else if (status.temperature == cmsup_pkg::ST_DERATING) begin
               mode_in  = cmsup_pkg::MODE_DERATING;
            end else begin
               mode_in  = cmsup_pkg::MODE_NORMAL;
            end
         end
         cmsup_pkg::MODE_DERATING: begin
            if (fail_hit) begin
               mode_in  = cmsup_pkg::MODE_FAILURE;
               count_in = '0;
            end else if (fault_hit) begin
               mode_in  = cmsup_pkg::MODE_FAULT;
               count_in = '0;
            end else if (hv_return) begin
               mode_in  = cmsup_pkg::MODE_READY;
            end else if (all_normal) begin
               mode_in  = cmsup_pkg::MODE_NORMAL;
            end else begin
               mode_in  = cmsup_pkg::MODE_DERATING;
            end
         end
         cmsup_pkg::MODE_FAULT: begin
            if (fail_hit) begin
               mode_in  = cmsup_pkg::MODE_FAILURE;
               count_in = '0;
            end else if (all_normal) begin
               mode_in  = cmsup_pkg::MODE_READY;
            end else begin
               mode_in  = cmsup_pkg::MODE_FAULT;
            end
         end
         cmsup_pkg::MODE_FAILURE: begin
            mode_in = all_normal ? cmsup_pkg::MODE_READY : cmsup_pkg::MODE_FAILURE;
         end
         default: begin
            mode_in = cmsup_pkg::MODE_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cmsup_pkg::MODE_READY;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   assign mode_next = mode_in;

   `ASSERT_NEXT(a_fail_clears_count, clock, reset,
      accept && fail_hit && (mode_ff != cmsup_pkg::MODE_FAILURE),
      count_ff == '0, "failure transaction did not clear ready counter")
   `ASSERT_IMPL(a_ready_exit_delay, clock, reset,
      accept && (mode_ff == cmsup_pkg::MODE_READY) && (mode_in == cmsup_pkg::MODE_NORMAL),
      delay_met && ready_flags, "left ready mode before the delay elapsed")
   `ASSERT_NEXT(a_idle_holds_state, clock, reset, !accept,
      $stable(mode_ff) && $stable(count_ff), "state changed without a transaction")

endmodule

/* hdl/converter_mode_supervisor_top.sv */
//------------------------------------------------------------------------------
// converter_mode_supervisor_top
// converter mode supervisor: five lane threshold compares feeding a mode update
//------------------------------------------------------------------------------
// the new mode is registered and is on rsp_mode in the cycle after the request transaction
// throughput: one transaction per cycle while req_stall is low
// a waiting response stalls the request side only while rsp_stall is high
// reset: mode ready, ready counter zero, threshold 0, ready delay 100
`timescale 1ns / 1ps

module converter_mode_supervisor_top #(
   parameter int SAMPLE_WIDTH = cmsup_pkg::SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = cmsup_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_hv_voltage_status,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_hv_current_status,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_lv_voltage_status,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_lv_current_status,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_temperature_status,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_battery_status,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_lv_overcurrent_status,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_bus_off_status,
   input  logic [cmsup_pkg::STATUS_W-1:0]      req_bus_timeout_status,
   input  logic                                req_converter_enable,
   input  logic [cmsup_pkg::MEAS_W-1:0]        req_measurement_lanes,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cmsup_pkg::MODE_W-1:0]        rsp_mode,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cmsup_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cmsup_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [cmsup_pkg::THR_W-1:0]   threshold_ff, threshold_in;
   logic [cmsup_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cmsup_pkg::MODE_W-1:0]  rsp_mode_ff, rsp_mode_in;
   logic                          req_accept;
   logic [cmsup_pkg::LANES-1:0]   lane_hit;
   cmsup_pkg::status_bus_type     status;
   cmsup_pkg::mode_type           mode_next;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_comb begin
      threshold_in = threshold_ff;
      delay_in     = delay_ff;
      if (csr_valid) begin
         case (csr_index)
            cmsup_pkg::CSR_FAIL_THRESHOLD: threshold_in = csr_wdata[cmsup_pkg::THR_W-1:0];
            cmsup_pkg::CSR_READY_DELAY:    delay_in     = csr_wdata[cmsup_pkg::DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= cmsup_pkg::FAIL_THRESHOLD_RST;
         delay_ff     <= cmsup_pkg::READY_DELAY_RST;
      end else begin
         threshold_ff <= threshold_in;
         delay_ff     <= delay_in;
      end
   end

   assign status = '{
      hv_voltage:     req_hv_voltage_status,
      hv_current:     req_hv_current_status,
      lv_voltage:     req_lv_voltage_status,
      lv_current:     req_lv_current_status,
      temperature:    req_temperature_status,
      battery:        req_battery_status,
      lv_overcurrent: req_lv_overcurrent_status,
      bus_off:        req_bus_off_status,
      bus_timeout:    req_bus_timeout_status,
      enable:         req_converter_enable
   };

   for (genvar i = 0; i < cmsup_pkg::LANES; i++) begin : g_lane
      cmsup_lane #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_lane (
         .sample    (req_measurement_lanes[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
         .threshold (threshold_ff),
         .hit       (lane_hit[i])
      );
   end

   cmsup_mode #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_mode (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .status      (status),
      .lane_hit    (lane_hit),
      .ready_delay (delay_ff),
      .mode_next   (mode_next)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mode_in  = rsp_mode_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_mode_in  = mode_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mode_ff <= rsp_mode_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mode  = rsp_mode_ff;

endmodule
